// ===== sv/hue_wheel_color_fader_core_macros.svh =====
// Assertion macros shared by the fader's checker.
`ifndef HUE_WHEEL_COLOR_FADER_CORE_MACROS_SVH
`define HUE_WHEEL_COLOR_FADER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HWCF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hue fader assertion failed");

// Next-cycle implication, checked outside reset.
`define HWCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hue fader assertion failed");

`endif

// ===== sv/hwcf_pkg.sv =====
// Types, constants and saturating helpers for the hue wheel color fader.
package hwcf_pkg;

  localparam int unsigned CompW  = 8;
  localparam int unsigned MsW    = 16;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CompW-1:0] COMP_MAX = 8'hFF;
  localparam logic [CompW-1:0] COMP_MIN = 8'h00;

  // Hue wheel phases.
  localparam logic [PhaseW-1:0] PH_RED_YEL = 3'd0;
  localparam logic [PhaseW-1:0] PH_YEL_GRN = 3'd1;
  localparam logic [PhaseW-1:0] PH_GRN_CYN = 3'd2;
  localparam logic [PhaseW-1:0] PH_CYN_BLU = 3'd3;
  localparam logic [PhaseW-1:0] PH_BLU_MAG = 3'd4;
  localparam logic [PhaseW-1:0] PH_MAG_RED = 3'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_FADE_ENABLE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TICK_DELAY  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_STEP_SIZE   = 2'd2;

  typedef struct packed {
    logic [CompW-1:0] red;
    logic [CompW-1:0] green;
    logic [CompW-1:0] blue;
  } color_t;

  typedef struct packed {
    logic             fade_enable;
    logic [MsW-1:0]   tick_delay;
    logic [CompW-1:0] step_size;
  } cfg_t;

  // Add with saturation at full scale.
  function automatic logic [CompW-1:0] sat_up(logic [CompW-1:0] c, logic [CompW-1:0] d);
    logic [CompW:0] s;
    s = {1'b0, c} + {1'b0, d};
    return s[CompW] ? COMP_MAX : s[CompW-1:0];
  endfunction

  // Subtract with saturation at zero.
  function automatic logic [CompW-1:0] sat_down(logic [CompW-1:0] c, logic [CompW-1:0] d);
    return (d >= c) ? COMP_MIN : (c - d);
  endfunction

endpackage

// ===== sv/hwcf_wheel.sv =====
// One step around the six-phase hue wheel, phases checked in wheel order.
module hwcf_wheel (
  input  logic [hwcf_pkg::PhaseW-1:0] phase,
  input  hwcf_pkg::color_t            color,
  input  logic [hwcf_pkg::CompW-1:0]  step_size,
  output logic [hwcf_pkg::PhaseW-1:0] phase_nxt,
  output hwcf_pkg::color_t            color_nxt
);

  // Each phase may hand over to the next one within the same step.
  always_comb begin
    logic [hwcf_pkg::PhaseW-1:0] ph;
    hwcf_pkg::color_t            c;
    ph = phase;
    c  = color;
    if (ph == hwcf_pkg::PH_RED_YEL) begin
      c.red   = hwcf_pkg::COMP_MAX;
      c.green = hwcf_pkg::sat_up(c.green, step_size);
      if (c.green == hwcf_pkg::COMP_MAX) ph = hwcf_pkg::PH_YEL_GRN;
    end
    if (ph == hwcf_pkg::PH_YEL_GRN) begin
      c.red = hwcf_pkg::sat_down(c.red, step_size);
      if (c.red == hwcf_pkg::COMP_MIN && c.green == hwcf_pkg::COMP_MAX)
        ph = hwcf_pkg::PH_GRN_CYN;
    end
    if (ph == hwcf_pkg::PH_GRN_CYN) begin
      c.blue = hwcf_pkg::sat_up(c.blue, step_size);
      if (c.green == hwcf_pkg::COMP_MAX && c.blue == hwcf_pkg::COMP_MAX)
        ph = hwcf_pkg::PH_CYN_BLU;
    end
    if (ph == hwcf_pkg::PH_CYN_BLU) begin
      c.green = hwcf_pkg::sat_down(c.green, step_size);
      if (c.green == hwcf_pkg::COMP_MIN && c.blue == hwcf_pkg::COMP_MAX)
        ph = hwcf_pkg::PH_BLU_MAG;
    end
    if (ph == hwcf_pkg::PH_BLU_MAG) begin
      c.red = hwcf_pkg::sat_up(c.red, step_size);
      if (c.red == hwcf_pkg::COMP_MAX && c.blue == hwcf_pkg::COMP_MAX)
        ph = hwcf_pkg::PH_MAG_RED;
    end
    if (ph == hwcf_pkg::PH_MAG_RED) begin
      c.blue = hwcf_pkg::sat_down(c.blue, step_size);
      if (c.red == hwcf_pkg::COMP_MAX && c.blue == hwcf_pkg::COMP_MIN) begin
        c.red   = hwcf_pkg::COMP_MAX;
        c.green = hwcf_pkg::COMP_MIN;
        c.blue  = hwcf_pkg::COMP_MIN;
        ph      = hwcf_pkg::PH_RED_YEL;
      end
    end
    phase_nxt = ph;
    color_nxt = c;
  end

endmodule

// ===== sv/hwcf_state.sv =====
// Fader state: tick counter, last millisecond value, hue phase and color.
module hwcf_state (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       update,
  input  logic [hwcf_pkg::MsW-1:0]   ms_count,
  input  hwcf_pkg::cfg_t             cfg,
  output hwcf_pkg::color_t           color_nxt
);

  logic [hwcf_pkg::PhaseW-1:0] phase_r, phase_nxt;
  logic [hwcf_pkg::MsW-1:0]    tick_r, tick_nxt;
  logic [hwcf_pkg::MsW-1:0]    last_ms_r, last_ms_nxt;
  hwcf_pkg::color_t            color_r;

  logic [hwcf_pkg::PhaseW-1:0] fix_phase;
  hwcf_pkg::color_t            fix_color;
  logic [hwcf_pkg::MsW-1:0]    tick_adv;
  logic                        do_step;
  logic [hwcf_pkg::PhaseW-1:0] wheel_phase;
  hwcf_pkg::color_t            wheel_color;

  // Recover from an impossible phase code before the tick logic runs.
  always_comb begin
    if (phase_r > hwcf_pkg::PH_MAG_RED) begin
      fix_phase       = hwcf_pkg::PH_RED_YEL;
      fix_color.red   = hwcf_pkg::COMP_MAX;
      fix_color.green = hwcf_pkg::COMP_MIN;
      fix_color.blue  = hwcf_pkg::COMP_MIN;
    end else begin
      fix_phase = phase_r;
      fix_color = color_r;
    end
  end

  // A new millisecond value advances the tick count; reaching the delay steps the wheel.
  assign tick_adv = (ms_count != last_ms_r) ? (tick_r + 1'b1) : tick_r;
  assign do_step  = (tick_adv == cfg.tick_delay);

  hwcf_wheel u_wheel (
    .phase     (fix_phase),
    .color     (fix_color),
    .step_size (cfg.step_size),
    .phase_nxt (wheel_phase),
    .color_nxt (wheel_color)
  );

  // Next state for this request; held entirely while fading is off.
  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    last_ms_nxt = last_ms_r;
    color_nxt   = color_r;
    if (cfg.fade_enable) begin
      last_ms_nxt = ms_count;
      if (do_step) begin
        tick_nxt  = '0;
        phase_nxt = wheel_phase;
        color_nxt = wheel_color;
      end else begin
        tick_nxt  = tick_adv;
        phase_nxt = fix_phase;
        color_nxt = fix_color;
      end
    end
  end

  // Commit the state when the request moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= hwcf_pkg::PH_RED_YEL;
      tick_r        <= '0;
      last_ms_r     <= '0;
      color_r.red   <= hwcf_pkg::COMP_MAX;
      color_r.green <= hwcf_pkg::COMP_MIN;
      color_r.blue  <= hwcf_pkg::COMP_MIN;
    end else if (update) begin
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      last_ms_r   <= last_ms_nxt;
      color_r     <= color_nxt;
    end
  end

endmodule

// ===== sv/hue_wheel_color_fader_core.sv =====
// Hue wheel color fader: takes one color request per cycle unless the result side stalls,
// each carrying the current millisecond counter, and returns one red/green/blue color per
// request. A request sits in an input register, the fader state is updated from it in a
// single combinational pass, and the color lands in a result register when its request
// moves on from the input register, so with no stall on the result side a new request can
// be accepted every cycle. A result that waits for out_ready holds the request behind it
// in the input register. That pass (tick compare plus the chained six-phase saturating
// wheel step) sets the clock period. Configuration writes are always accepted and take
// effect at once; they are meant to be made only while no request is in flight.
module hue_wheel_color_fader_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hwcf_pkg::MsW-1:0]       in_ms_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hwcf_pkg::CompW-1:0]     out_red,
  output logic [hwcf_pkg::CompW-1:0]     out_green,
  output logic [hwcf_pkg::CompW-1:0]     out_blue,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hwcf_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [hwcf_pkg::CfgDataW-1:0]  cfg_data
);

  hwcf_pkg::cfg_t             cfg_r;
  logic                       s1_valid_r;
  logic [hwcf_pkg::MsW-1:0]   s1_ms_r;
  logic                       out_valid_r;
  hwcf_pkg::color_t           out_color_r;
  hwcf_pkg::color_t           color_nxt;
  logic                       advance;

  // Configuration registers; indexes past the list are ignored.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fade_enable <= 1'b1;
      cfg_r.tick_delay  <= 16'd1;
      cfg_r.step_size   <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hwcf_pkg::REG_FADE_ENABLE: cfg_r.fade_enable <= cfg_data[0];
        hwcf_pkg::REG_TICK_DELAY:  cfg_r.tick_delay  <= cfg_data;
        hwcf_pkg::REG_STEP_SIZE:   cfg_r.step_size   <= cfg_data[hwcf_pkg::CompW-1:0];
        default: ;
      endcase
    end
  end

  // The held request moves on whenever the result register is free or being drained.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ms_r <= in_ms_count;
    end
  end

  hwcf_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .update    (advance),
    .ms_count  (s1_ms_r),
    .cfg       (cfg_r),
    .color_nxt (color_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_color_r <= color_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_color_r.red;
  assign out_green = out_color_r.green;
  assign out_blue  = out_color_r.blue;

endmodule

// ===== sv/hwcf_checker.sv =====
// Port-level checks for the hue wheel color fader, bound to the top level.
`include "hue_wheel_color_fader_core_macros.svh"

module hwcf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [hwcf_pkg::CompW-1:0]     out_red,
  input logic [hwcf_pkg::CompW-1:0]     out_green,
  input logic [hwcf_pkg::CompW-1:0]     out_blue,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);

  logic [3*hwcf_pkg::CompW-1:0] out_rgb;
  logic                         any_full;

  // Whole result color, and whether one component sits at full scale.
  assign out_rgb  = {out_red, out_green, out_blue};
  assign any_full = (out_red == hwcf_pkg::COMP_MAX) || (out_green == hwcf_pkg::COMP_MAX) ||
                    (out_blue == hwcf_pkg::COMP_MAX);

  // A stalled result keeps its color.
  `HWCF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_rgb))

  // Every color on the wheel has one component at full scale.
  `HWCF_ASSERT_IMPL(a_on_wheel, clk, rst_n, out_valid, any_full)

  // With the result register empty, a new request is always taken.
  `HWCF_ASSERT_IMPL(a_in_free, clk, rst_n, !out_valid, in_ready)

  // Configuration writes never stall.
  `HWCF_ASSERT_IMPL(a_cfg_free, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind hue_wheel_color_fader_core hwcf_checker u_hwcf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_red     (out_red),
  .out_green   (out_green),
  .out_blue    (out_blue),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready)
);
